// ===== sv/per_source_rate_aligned_packet_framer_unit_macros.svh =====
// Assertion macros shared by the packet framer RTL.
// Clocked on clk_i, disabled while rst_ni is low; needs no other file.
`ifndef PER_SOURCE_RATE_ALIGNED_PACKET_FRAMER_UNIT_MACROS_SVH
`define PER_SOURCE_RATE_ALIGNED_PACKET_FRAMER_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define PFR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define PFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pfr_pkg.sv =====
// Shared types, constants and the header byte selector of the packet framer.
// No dependencies.
package pfr_pkg;

  localparam int unsigned MaxSourcesDef = 16;
  localparam int unsigned HeaderBytes   = 22;
  localparam int unsigned HdrIdxW       = $clog2(HeaderBytes);
  localparam int unsigned SyncCount     = 5;
  localparam logic [7:0]  SyncByte      = 8'hAA;

  // header byte offsets
  localparam logic [HdrIdxW-1:0] FlagOff = HdrIdxW'(5);
  localparam logic [HdrIdxW-1:0] IdOff   = HdrIdxW'(6);
  localparam logic [HdrIdxW-1:0] RateOff = HdrIdxW'(10);
  localparam logic [HdrIdxW-1:0] NumOff  = HdrIdxW'(14);
  localparam logic [HdrIdxW-1:0] SizeOff = HdrIdxW'(18);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] call_records;
    logic [15:0] record_bytes;
    logic [15:0] records_per_cycle;
    logic [31:0] source_id;
    logic [3:0]  source_slot;
  } item_t;

  // counter update request, issued once per packet header
  typedef struct packed {
    logic        upd;
    logic [15:0] cnt_base;
    logic [15:0] num;
    logic [15:0] rate;
  } tbl_upd_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic        seq_begin;
  } tbl_rsp_t;

  function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] sel);
    logic [7:0] b;
    unique case (sel)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] hdr_byte(logic [HdrIdxW-1:0] idx, logic [31:0] id,
                                          logic [15:0] rate, logic [15:0] num,
                                          logic [15:0] size, logic flag);
    logic [7:0] b;
    logic [HdrIdxW-1:0] off;
    off = '0;
    b   = SyncByte;
    priority if (idx < FlagOff) begin
      b = SyncByte;
    end else if (idx == FlagOff) begin
      b = {7'd0, flag};
    end else if (idx < RateOff) begin
      off = idx - IdOff;
      b   = word_byte(id, off[1:0]);
    end else if (idx < NumOff) begin
      off = idx - RateOff;
      b   = word_byte({16'd0, rate}, off[1:0]);
    end else if (idx < SizeOff) begin
      off = idx - NumOff;
      b   = word_byte({16'd0, num}, off[1:0]);
    end else begin
      off = idx - SizeOff;
      b   = word_byte({16'd0, size}, off[1:0]);
    end
    return b;
  endfunction

endpackage

// ===== sv/per_source_rate_aligned_packet_framer_unit.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: slot, id, rate, size, count, byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: byte; tuser: start, last; tlast
// cfg       in   cfg_we_i                     cfg_wdata_i: active source count
//
// One data byte per cycle unless the output stalls; a packet header adds 22
// bytes while the held transaction waits in the input register. Results leave
// through one output register, and an output stall stalls the input. Reset
// clears counters, marks and the call state at once; no clearing pass is needed.
// Top level of the framer: input register plus sequencer and source table.
// Depends on pfr_pkg, pfr_src_table and pfr_emit.
module per_source_rate_aligned_packet_framer_unit import pfr_pkg::*; #(
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] source_slot, [35:4] source_id, [51:36] records_per_cycle,
  // [67:52] record_bytes, [83:68] call_records, [91:84] data_byte
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,  // [0] packet_start, [1] last
  output logic        m_axis_tlast   // call_end
);

  item_t    item_q;
  logic     item_valid_q, item_pop;
  tbl_upd_t upd;
  tbl_rsp_t rsp;

  assign s_axis_tready = !item_valid_q || item_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
  end

  pfr_src_table #(
    .MAX_SOURCES(MAX_SOURCES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .slot_i     (item_q.source_slot),
    .upd_i      (upd),
    .rsp_o      (rsp)
  );

  pfr_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .item_pop_o   (item_pop),
    .rsp_i        (rsp),
    .upd_o        (upd),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== sv/pfr_src_table.sv =====
// Per-source record counters, cycle-done marks, sequence-begin flag and the
// active source register. Depends on pfr_pkg.
module pfr_src_table import pfr_pkg::*; #(
  parameter int unsigned MAX_SOURCES = MaxSourcesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic [3:0] slot_i,
  input  tbl_upd_t   upd_i,
  output tbl_rsp_t   rsp_o
);

  localparam int unsigned SlotW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  logic [15:0]            cnt_q [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] mask_q, mask_d, mask_set, act_mask;
  logic                   seq_q, all_done, wrap;
  logic [4:0]             active_q, active_d;
  logic [SlotW-1:0]       slot_idx;
  logic [16:0]            sum;

  // slot wrap to the table depth, as a small constant lookup
  always_comb begin
    slot_idx = '0;
    for (int i = 0; i < 16; i++) begin
      if (slot_i == 4'(i)) slot_idx = SlotW'(i % MAX_SOURCES);
    end
  end

  assign rsp_o.cnt       = cnt_q[slot_idx];
  assign rsp_o.seq_begin = seq_q;

  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      act_mask[i] = (32'(active_q) > i);
      mask_set[i] = (slot_idx == SlotW'(i));
    end
  end

  assign sum      = {1'b0, upd_i.cnt_base} + {1'b0, upd_i.num};
  assign wrap     = (sum == {1'b0, upd_i.rate});
  assign mask_d   = wrap ? (mask_q | mask_set) : mask_q;
  // only active slots count toward the all-done test
  assign all_done = &(mask_d | ~act_mask);

  always_comb begin
    active_d = cfg_wdata_i;
    if (cfg_wdata_i == 5'd0) begin
      active_d = 5'd1;
    end else if (32'(cfg_wdata_i) > MAX_SOURCES) begin
      active_d = 5'(MAX_SOURCES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SOURCES; i++) cnt_q[i] <= '0;
      mask_q   <= '0;
      seq_q    <= 1'b1;
      active_q <= 5'd1;
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_SOURCES; i++) cnt_q[i] <= '0;
      mask_q   <= '0;
      seq_q    <= 1'b1;
      active_q <= active_d;
    end else if (upd_i.upd) begin
      cnt_q[slot_idx] <= wrap ? 16'd0 : sum[15:0];
      mask_q          <= all_done ? '0 : mask_d;
      seq_q           <= all_done;
    end
  end

endmodule

// ===== sv/pfr_emit.sv =====
// Framing sequencer and output register: header insertion, record and call
// tracking. Depends on pfr_pkg and the assertion macro header.
`include "per_source_rate_aligned_packet_framer_unit_macros.svh"

module pfr_emit import pfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  input  tbl_rsp_t   rsp_i,
  output tbl_upd_t   upd_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser,  // [0] packet_start, [1] last
  output logic       m_axis_tlast   // call_end
);

  logic               hdr_act_q;
  logic [HdrIdxW-1:0] hdr_idx_q;
  logic [15:0]        num_q, cnt_base_q, bir_q, rlc_q, rlp_q;
  logic               flag_q;
  logic               m_valid_q, start_q, last_q, call_end_q;
  logic [7:0]         byte_q;

  logic        adv, need_hdr, rec_end, last_rec;
  logic [15:0] rate_eff, rbytes_eff, crec_eff, cnt_eff, room, rlc_eff, num_new;

  assign adv      = item_valid_i && (!m_valid_q || m_axis_tready);
  assign need_hdr = !hdr_act_q && (rlp_q == 16'd0);

  assign rate_eff   = (item_i.records_per_cycle == 16'd0) ? 16'd1 : item_i.records_per_cycle;
  assign rbytes_eff = (item_i.record_bytes == 16'd0) ? 16'd1 : item_i.record_bytes;
  assign crec_eff   = (item_i.call_records == 16'd0) ? 16'd1 : item_i.call_records;

  // counter at or past the rate restarts the cycle
  assign cnt_eff = (rsp_i.cnt >= rate_eff) ? 16'd0 : rsp_i.cnt;
  assign room    = rate_eff - cnt_eff;
  assign rlc_eff = (rlc_q == 16'd0) ? crec_eff : rlc_q;
  assign num_new = (room > rlc_eff) ? rlc_eff : room;

  assign rec_end  = ({1'b0, bir_q} + 17'd1) >= {1'b0, rbytes_eff};
  assign last_rec = (rlc_q == 16'd1);

  assign item_pop_o = adv && !need_hdr && !hdr_act_q;

  // counters are committed while the second header byte goes out
  assign upd_o.upd      = adv && hdr_act_q && (hdr_idx_q == HdrIdxW'(1));
  assign upd_o.cnt_base = cnt_base_q;
  assign upd_o.num      = num_q;
  assign upd_o.rate     = rate_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_act_q  <= 1'b0;
      hdr_idx_q  <= '0;
      num_q      <= '0;
      cnt_base_q <= '0;
      flag_q     <= 1'b0;
      bir_q      <= '0;
      rlc_q      <= '0;
      rlp_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (adv) begin
        if (need_hdr) begin
          hdr_act_q  <= 1'b1;
          hdr_idx_q  <= HdrIdxW'(1);
          num_q      <= num_new;
          cnt_base_q <= cnt_eff;
          flag_q     <= rsp_i.seq_begin;
          rlc_q      <= rlc_eff;
          rlp_q      <= num_new;
          bir_q      <= '0;
        end else if (hdr_act_q) begin
          hdr_idx_q <= hdr_idx_q + HdrIdxW'(1);
          if (hdr_idx_q == HdrIdxW'(HeaderBytes - 1)) begin
            hdr_act_q <= 1'b0;
          end
        end else if (rec_end) begin
          bir_q <= '0;
          rlc_q <= rlc_q - 16'd1;
          rlp_q <= last_rec ? 16'd0 : (rlp_q - 16'd1);
        end else begin
          bir_q <= bir_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (need_hdr) begin
        byte_q     <= SyncByte;
        start_q    <= 1'b1;
        last_q     <= 1'b0;
        call_end_q <= 1'b0;
      end else if (hdr_act_q) begin
        byte_q     <= hdr_byte(hdr_idx_q, item_i.source_id, item_i.records_per_cycle,
                               num_q, item_i.record_bytes, flag_q);
        start_q    <= 1'b0;
        last_q     <= 1'b0;
        call_end_q <= 1'b0;
      end else begin
        byte_q     <= item_i.data_byte;
        start_q    <= 1'b0;
        last_q     <= 1'b1;
        call_end_q <= rec_end && last_rec;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = byte_q;
  assign m_axis_tuser  = {last_q, start_q};
  assign m_axis_tlast  = call_end_q;

  `PFR_ASSERT_IMP(a_hdr_num_nonzero, hdr_act_q, num_q != 16'd0, "empty packet header")
  `PFR_ASSERT_IMP(a_pop_only_data, item_pop_o, !hdr_act_q && !need_hdr, "item popped in header")
  `PFR_ASSERT_IMP(a_start_not_last, m_valid_q && start_q, !last_q && !call_end_q,
    "packet start flagged as item end")
  `PFR_ASSERT_NXT(a_upd_commits_packet, upd_o.upd, hdr_act_q && rlp_q == num_q,
    "counter update outside header")

endmodule

// ===== dv/per_source_rate_aligned_packet_framer_unit_test.sv =====
// Self-checking testbench for the per-source rate-aligned packet framer.
// Predicts every framed byte and compares it with the output stream.
// Depends on pfr_pkg and per_source_rate_aligned_packet_framer_unit only.
`timescale 1ns / 1ps

module per_source_rate_aligned_packet_framer_unit_test import pfr_pkg::*; ();

  localparam int CycleLimit = 600000;
  localparam int NumSlots   = 16;
  localparam int LongHold   = 250;

  typedef struct {
    logic [7:0] value;
    logic       pkt_start;
    logic       call_end;
    logic       is_last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // framer model state
  logic [15:0] src_count [NumSlots];
  logic [15:0] cycle_mask;
  logic        seq_begin_flag;
  logic [15:0] rec_pos;
  logic [15:0] calls_left;
  logic [15:0] pkt_left;
  int          active_cnt;

  beat_t       framed_q [$];
  beat_t       want_beat;

  // per-source traffic profile for random calls
  logic [15:0] src_rate [NumSlots];
  logic [31:0] src_id   [NumSlots];

  int  err_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  bit  sender_calm = 1'b0;
  bit  noisy = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  per_source_rate_aligned_packet_framer_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 100)
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output check: one transaction against the oldest predicted beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (framed_q.size() == 0) begin
        report_mismatch("output transaction with nothing expected", 32'(m_axis_tdata), 0);
      end else begin
        want_beat = framed_q.pop_front();
        if (m_axis_tdata !== want_beat.value)
          report_mismatch("out_byte", 32'(m_axis_tdata), 32'(want_beat.value));
        if (m_axis_tuser[0] !== want_beat.pkt_start)
          report_mismatch("packet_start", 32'(m_axis_tuser[0]), 32'(want_beat.pkt_start));
        if (m_axis_tlast !== want_beat.call_end)
          report_mismatch("call_end", 32'(m_axis_tlast), 32'(want_beat.call_end));
        if (m_axis_tuser[1] !== want_beat.is_last)
          report_mismatch("last", 32'(m_axis_tuser[1]), 32'(want_beat.is_last));
      end
    end
  end

  task automatic push_beat(input logic [7:0] v, input logic s, input logic ce, input logic l);
    beat_t b;
    b.value = v;
    b.pkt_start = s;
    b.call_end = ce;
    b.is_last = l;
    framed_q.insert(framed_q.size(), b);
  endtask

  task automatic clear_sources();
    for (int i = 0; i < NumSlots; i++) src_count[i] = '0;
    cycle_mask = '0;
    seq_begin_flag = 1'b1;
  endtask

  // Frames one accepted data byte: optional 22-byte header, then the byte
  task automatic frame_item(input item_t it);
    logic [15:0]  rate;
    logic [15:0]  rb;
    logic [15:0]  cnt;
    logic [15:0]  n;
    logic [127:0] hdr;
    logic         all_done;
    logic         ce;
    int           s;
    s = int'(it.source_slot);
    rate = (it.records_per_cycle == '0) ? 16'd1 : it.records_per_cycle;
    rb = (it.record_bytes == '0) ? 16'd1 : it.record_bytes;
    if (calls_left == '0) begin
      calls_left = (it.call_records == '0) ? 16'd1 : it.call_records;
      pkt_left = '0;
      rec_pos = '0;
    end
    if (pkt_left == '0) begin
      cnt = src_count[s];
      if (cnt >= rate) cnt = '0;   // source starts a new cycle
      n = rate - cnt;
      if (n > calls_left) n = calls_left;
      for (int i = 0; i < SyncCount; i++) push_beat(SyncByte, i == 0, 1'b0, 1'b0);
      push_beat({7'd0, seq_begin_flag}, 1'b0, 1'b0, 1'b0);
      hdr = {16'd0, it.record_bytes, 16'd0, n, 16'd0, it.records_per_cycle, it.source_id};
      for (int i = 0; i < 16; i++) push_beat(hdr[8*i +: 8], 1'b0, 1'b0, 1'b0);
      pkt_left = n;
      rec_pos = '0;
      cnt = cnt + n;
      if (cnt == rate) begin
        cnt = '0;
        cycle_mask[s] = 1'b1;
      end
      src_count[s] = cnt;
      all_done = 1'b1;
      for (int i = 0; i < active_cnt; i++)
        if (!cycle_mask[i]) all_done = 1'b0;
      seq_begin_flag = all_done;
      if (all_done) cycle_mask = '0;
    end
    ce = 1'b0;
    if (int'(rec_pos) + 1 >= int'(rb)) begin
      rec_pos = '0;
      pkt_left--;
      calls_left--;
      if (calls_left == '0) begin
        pkt_left = '0;
        ce = 1'b1;
      end
    end else begin
      rec_pos++;
    end
    push_beat(it.data_byte, 1'b0, ce, 1'b1);
  endtask

  function automatic item_t mk_item(input logic [3:0] slot, input logic [31:0] id,
                                    input logic [15:0] rate, input logic [15:0] rb,
                                    input logic [15:0] crec, input logic [7:0] data);
    item_t it;
    it.source_slot = slot;
    it.source_id = id;
    it.records_per_cycle = rate;
    it.record_bytes = rb;
    it.call_records = crec;
    it.data_byte = data;
    return it;
  endfunction

  // Offers one item, waits for the input handshake, then predicts its output
  task automatic send_byte(input item_t it);
    if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    frame_item(it);
  endtask

  // One whole call; with noise on, later bytes carry junk call counts and
  // now and then a record size that changes inside a record
  task automatic send_call(input logic [3:0] slot, input logic [31:0] id,
                           input logic [15:0] rate, input logic [15:0] rb,
                           input logic [15:0] crec);
    item_t it;
    do begin
      it = mk_item(slot, id, rate, rb, crec, 8'($urandom));
      if (noisy && calls_left != '0) begin
        if ($urandom_range(0, 1) == 1) it.call_records = 16'($urandom);
        if ($urandom_range(0, 11) == 0) it.record_bytes = 16'($urandom);
      end
      send_byte(it);
    end while (calls_left != '0);
  endtask

  // Sender pause: wait for every predicted beat, then let the pipe settle
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_active_sources(input logic [4:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_cnt = (v == 5'd0) ? 1 : (v > 5'd16) ? 16 : int'(v);
    clear_sources();
  endtask

  task automatic random_call(input int act);
    logic [3:0]  slot;
    logic [15:0] rb;
    logic [15:0] crec;
    slot = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, act - 1));
    case ($urandom_range(0, 39))
      0:       src_rate[slot] = 16'($urandom);                // random rate, mostly huge, rarely wraps
      1:       src_rate[slot] = 16'd0;
      2, 3:    src_rate[slot] = 16'($urandom_range(1, 8));    // may drop below counter
      4:       src_id[slot] = $urandom;
      default: ;
    endcase
    rb = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    crec = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    sender_calm = ($urandom_range(0, 3) == 0);
    send_call(slot, src_id[slot], src_rate[slot], rb, crec);
  endtask

  task automatic test_directed();
    noisy = 1'b0;
    send_call(4'd0, 32'hFFFF_FFFF, 16'd2, 16'd1, 16'd3);   // two packets, cycle wrap
    send_call(4'd1, 32'h0, 16'd0, 16'd0, 16'd0);           // zero fields, inactive slot
    send_call(4'd15, 32'h1234_5678, 16'hFFFF, 16'd2, 16'd1);
    // record size shrinks inside a record, ending it early
    send_byte(mk_item(4'd0, 32'hA5A5_5A5A, 16'd5, 16'hFFFF, 16'd1, 8'h00));
    send_byte(mk_item(4'd0, 32'hA5A5_5A5A, 16'd5, 16'hFFFF, 16'd1, 8'hFF));
    send_byte(mk_item(4'd0, 32'hA5A5_5A5A, 16'd5, 16'h8000, 16'd1, 8'h5A));
    send_byte(mk_item(4'd0, 32'hA5A5_5A5A, 16'd5, 16'd2, 16'd1, 8'hA5));
    // counter left above a later, smaller rate
    send_call(4'd2, 32'h0000_CAFE, 16'd10, 16'd1, 16'd4);
    send_call(4'd2, 32'h0000_CAFE, 16'd3, 16'd1, 16'd2);
    drain_all();
  endtask

  // Complete rounds over all active sources so the begin flag comes back
  task automatic test_active_sweep();
    write_active_sources(5'd0);
    send_call(4'd0, 32'h1, 16'd1, 16'd1, 16'd1);
    send_call(4'd3, 32'h2, 16'd2, 16'd1, 16'd1);
    drain_all();
    write_active_sources(5'd31);
    for (int s = 0; s < NumSlots; s++) send_call(4'(s), 32'(s), 16'd1, 16'd1, 16'd1);
    send_call(4'd7, 32'h7, 16'd1, 16'd1, 16'd1);
    drain_all();
    write_active_sources(5'd3);
    for (int r = 0; r < 2; r++)
      for (int s = 0; s < 3; s++) send_call(4'(s), 32'h100 + 32'(s), 16'd2, 16'd1, 16'd1);
    send_call(4'd1, 32'h101, 16'd2, 16'd1, 16'd1);
    drain_all();
    write_active_sources(5'd16);
    send_call(4'd9, 32'h9, 16'd1, 16'd1, 16'd1);
    send_call(4'd15, 32'hF, 16'd2, 16'd1, 16'd2);
    drain_all();
    write_active_sources(5'd1);
    send_call(4'd0, 32'hFEED_0000, 16'd1, 16'd1, 16'd2);
    drain_all();
  endtask

  task automatic test_backpressure();
    hold_req <= ~hold_req;
    sender_calm = 1'b1;
    send_call(4'd0, 32'h0BAD_F00D, 16'd4, 16'd3, 16'd12);
    drain_all();
    send_call(4'd0, 32'h0BAD_F00D, 16'd4, 16'd2, 16'd3);
    sender_calm = 1'b0;
    drain_all();
  endtask

  task automatic test_random_traffic();
    logic [4:0] acts [3];
    int         goal;
    acts = '{5'd5, 5'd16, 5'd2};
    noisy = 1'b1;
    for (int s = 0; s < NumSlots; s++) begin
      src_rate[s] = 16'($urandom_range(1, 6));
      src_id[s] = $urandom;
    end
    for (int p = 0; p < 3; p++) begin
      write_active_sources(acts[p]);
      goal = items_sent + 85;
      while (items_sent < goal) random_call(active_cnt);
      drain_all();
    end
  endtask

  task automatic test_quiet_tail();
    int goal;
    quiet = 1'b1;
    sender_calm = 1'b1;
    goal = items_sent + 30;
    while (items_sent < goal) random_call(active_cnt);
    drain_all();
  endtask

  initial begin
    active_cnt = 1;
    clear_sources();
    rec_pos = '0;
    calls_left = '0;
    pkt_left = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_active_sweep();
    test_backpressure();
    test_random_traffic();
    test_quiet_tail();
    repeat (10) @(posedge clk_i);
    if (framed_q.size() != 0)
      report_mismatch("beats never produced", framed_q.size(), 0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
